/* src/cle_pkg.sv */
// Shared types and codes for the cursor list engine.
// Depends on nothing; used by cle_cell, cursor_list_engine, cle_checker and the testbench.
`default_nettype none
package cle_pkg;

  // Operation codes carried in s_tuser.
  localparam logic [3:0] K_PREPEND   = 4'd0;
  localparam logic [3:0] K_APPEND    = 4'd1;
  localparam logic [3:0] K_INS_AFTER = 4'd2;
  localparam logic [3:0] K_INS_BEFORE= 4'd3;
  localparam logic [3:0] K_UPDATE    = 4'd4;
  localparam logic [3:0] K_DELETE    = 4'd5;
  localparam logic [3:0] K_FIRST     = 4'd6;
  localparam logic [3:0] K_LAST      = 4'd7;
  localparam logic [3:0] K_NEXT      = 4'd8;
  localparam logic [3:0] K_PREV      = 4'd9;
  localparam logic [3:0] K_GOTO      = 4'd10;
  localparam logic [3:0] K_FIND      = 4'd11;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BOUNDARY = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  // What every cell of the row does in a cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ROT,
    CELL_INS,
    CELL_DEL,
    CELL_WR
  } cell_op_t;

endpackage
`default_nettype wire

/* src/cursor_list_engine.sv */
// Top level of the cursor list engine: control, cursor state and the cell row.
// Depends on cle_pkg and cle_cell.
//
//   channel | dir | accepted when           | payload
//   s_*     | in  | s_tvalid & s_tready     | operation kind, value, index
//   m_*     | out | m_tvalid & m_tready     | status, cursor value/position, count, flags
//
// The execute state applies the edit to the row, then the row rotates once round its
// CAPACITY cells while the head cell is watched for the cursor element or a match,
// and the result is offered once the scan ends (a find first settles its match).
// The next item is taken in the cycle after the result transfer.
// Reset leaves the list empty at once. A stalled result holds the block.
`default_nettype none
module cursor_list_engine
  import cle_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // value[31:0], index[39:32]
  input  wire logic [3:0]  s_tuser,  // kind[3:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata   // status[2:0], cur_value[34:3], cur_position[42:35],
                                     // count[51:43], at_first[52], at_last[53], zero[55:54]
);

  localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [PW-1:0] STEP_LAST = PW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_OUT} state_t;

  state_t        state;
  logic [3:0]    kind;
  logic [31:0]   value;
  logic [7:0]    index;
  logic [CW-1:0] cnt, cnt_next;
  logic [PW-1:0] pos, pos_next;
  logic [2:0]    status, status_next;
  logic [PW-1:0] step;
  logic          found;
  logic [PW-1:0] fpos;
  logic [31:0]   fval;
  logic [31:0]   cur_val;

  cell_op_t      row_op, exec_op;
  logic [PW-1:0] row_pos, exec_pos;
  logic [31:0]   cell_q [CAPACITY];

  logic          empty, full, in_list, match;
  logic [CW-1:0] last;

  assign empty   = (cnt == '0);
  assign full    = (cnt >= CAP_CNT);
  assign last    = empty ? '0 : cnt - CW'(1);
  assign in_list = ({1'b0, CW'(step)} < {1'b0, cnt});
  assign match   = (kind == K_FIND) && in_list && (cell_q[0] == value);

  always_comb begin
    status_next = ST_OK;
    cnt_next    = cnt;
    pos_next    = pos;
    exec_op     = CELL_HOLD;
    exec_pos    = pos;
    if (kind == K_PREPEND || kind == K_APPEND) begin
      if (full) status_next = ST_FULL;
      else begin
        exec_op  = CELL_INS;
        cnt_next = cnt + CW'(1);
        if (kind == K_PREPEND) begin
          exec_pos = '0;
          pos_next = '0;
        end else begin
          exec_pos = PW'(cnt);
          pos_next = PW'(cnt);
        end
      end
    end else if (kind == K_GOTO) begin
      if (32'(index) >= 32'(cnt)) status_next = ST_RANGE;
      else pos_next = PW'(index);
    end else if (empty) begin
      status_next = ST_EMPTY;
    end else begin
      case (kind)
        K_INS_AFTER, K_INS_BEFORE: begin
          if (full) status_next = ST_FULL;
          else begin
            exec_op  = CELL_INS;
            cnt_next = cnt + CW'(1);
            if (kind == K_INS_AFTER) begin
              exec_pos = pos + PW'(1);
              pos_next = pos + PW'(1);
            end
          end
        end
        K_UPDATE: exec_op = CELL_WR;
        K_DELETE: begin
          exec_op  = CELL_DEL;
          cnt_next = cnt - CW'(1);
          pos_next = '0;
        end
        K_FIRST: pos_next = '0;
        K_LAST:  pos_next = PW'(last);
        K_NEXT: begin
          if (CW'(pos) >= last) status_next = ST_BOUNDARY;
          else pos_next = pos + PW'(1);
        end
        K_PREV: begin
          if (pos == '0) status_next = ST_BOUNDARY;
          else pos_next = pos - PW'(1);
        end
        default: status_next = ST_OK;
      endcase
    end
  end

  always_comb begin
    row_op  = CELL_HOLD;
    row_pos = exec_pos;
    if (state == S_EXEC) row_op = exec_op;
    else if (state == S_SCAN) row_op = CELL_ROT;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_row
    logic [31:0] lv, rv;
    if (i == 0) begin : g_l0
      assign lv = cell_q[0];
    end else begin : g_ln
      assign lv = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_rl
      assign rv = cell_q[0];
    end else begin : g_rn
      assign rv = cell_q[i+1];
    end
    cle_cell #(.PW(PW), .IDX(i)) u_cell (
      .clk      (clk),
      .op       (row_op),
      .at_pos   (row_pos),
      .wr_val   (value),
      .left_val (lv),
      .right_val(rv),
      .val      (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      pos    <= '0;
      status <= ST_OK;
      step   <= '0;
      found  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind  <= s_tuser;
            value <= s_tdata[31:0];
            index <= s_tdata[39:32];
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          status <= status_next;
          cnt    <= cnt_next;
          pos    <= pos_next;
          step   <= '0;
          found  <= 1'b0;
          state  <= S_SCAN;
        end
        S_SCAN: begin
          if (step == pos) cur_val <= cell_q[0];
          if (match && !found) begin
            found <= 1'b1;
            fpos  <= step;
            fval  <= cell_q[0];
          end
          step <= step + PW'(1);
          if (step == STEP_LAST) state <= S_OUT;
        end
        S_OUT: begin
          if (kind == K_FIND && status == ST_OK && !empty) begin
            // Resolve the search once, on entry to the result state.
            if (found) begin
              pos     <= fpos;
              cur_val <= fval;
              found   <= 1'b0;
              kind    <= K_FIRST;
            end else begin
              status <= ST_NOTFOUND;
            end
          end else if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A pending search result is settled before the transfer is offered.
  logic find_open;
  assign find_open = (kind == K_FIND) && (status == ST_OK) && !empty;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT) && !find_open;

  always_comb begin
    m_tdata        = '0;
    m_tdata[2:0]   = status;
    m_tdata[51:43] = 9'(cnt);
    if (!empty) begin
      m_tdata[34:3]  = cur_val;
      m_tdata[42:35] = 8'(pos);
      m_tdata[52]    = (pos == '0);
      m_tdata[53]    = (CW'(pos) == last);
    end
  end

  a_handshake_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input and output open together");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CAP_CNT) else $error("element count beyond capacity");
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !empty) |-> (CW'(pos) < cnt)) else $error("cursor beyond list");
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |=> s_tready) else $error("no return to idle after result");

endmodule
`default_nettype wire

/* src/cle_cell.sv */
// One storage cell of the list row: holds the element at its position.
// Depends on cle_pkg; instantiated in a row by cursor_list_engine.
`default_nettype none
module cle_cell
  import cle_pkg::*;
#(
  parameter int PW  = 8,
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire cell_op_t      op,
  input  wire logic [PW-1:0] at_pos,
  input  wire logic [31:0]   wr_val,
  input  wire logic [31:0]   left_val,
  input  wire logic [31:0]   right_val,
  output logic [31:0]        val
);

  localparam logic [PW-1:0] MY_POS = PW'(IDX);

  always_ff @(posedge clk) begin
    case (op)
      CELL_ROT: val <= right_val;
      CELL_INS: begin
        if (MY_POS == at_pos) val <= wr_val;
        else if (MY_POS > at_pos) val <= left_val;
      end
      CELL_DEL: begin
        if (MY_POS >= at_pos) val <= right_val;
      end
      CELL_WR: begin
        if (MY_POS == at_pos) val <= wr_val;
      end
      default: val <= val;
    endcase
  end

endmodule
`default_nettype wire

/* tb/cle_checker.sv */
// Checker for the cursor list engine: watches both stream channels, keeps its own
// copy of the list and compares every result transfer. Depends on cle_pkg.
`timescale 1ns / 100ps
module cle_checker
  import cle_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [39:0] s_tdata,  // value[31:0], index[39:32]
  input  wire logic [3:0]  s_tuser,  // kind[3:0]
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [55:0] m_tdata,  // status, cur_value, cur_position, count, at_first, at_last
  output int               failures,
  output int               outstanding,
  output int               list_len
);

  localparam int DEPTH = 256;

  typedef struct packed {
    logic [1:0]  pad;
    logic        at_last;
    logic        at_first;
    logic [8:0]  count;
    logic [7:0]  position;
    logic [31:0] value;
    logic [2:0]  status;
  } cursor_report_t;

  logic [31:0] pool_data [DEPTH];
  logic [7:0]  pool_link [DEPTH];
  logic [7:0]  head, tail, cur, free_head;
  logic [7:0]  cur_pos;
  logic [8:0]  len;
  cursor_report_t pending_reports[$];

  assign outstanding = pending_reports.size();
  assign list_len = len;

  function automatic logic [7:0] node_at(int pos);
    logic [7:0] p;
    p = head;
    for (int i = 0; i < pos; i++) p = pool_link[p];
    return p;
  endfunction

  function automatic logic [7:0] grab_node(logic [31:0] v);
    logic [7:0] n;
    n = free_head;
    free_head = pool_link[n];
    pool_data[n] = v;
    return n;
  endfunction

  task automatic push_front(logic [31:0] v);
    logic [7:0] n;
    n = grab_node(v);
    pool_link[n] = head;
    if (len == 0) tail = n;
    head = n;
    cur = n;
    cur_pos = 0;
    len++;
  endtask

  task automatic push_back(logic [31:0] v);
    logic [7:0] n;
    n = grab_node(v);
    pool_link[n] = 0;
    if (len == 0) head = n;
    else pool_link[tail] = n;
    tail = n;
    cur = n;
    len++;
    cur_pos = 8'(len - 1);
  endtask

  task automatic apply_op(logic [3:0] kind, logic [31:0] v, logic [7:0] idx,
                          output cursor_report_t rep);
    logic [2:0] st;
    logic [7:0] b, c, n, p;
    int last;
    bit full;
    st = ST_OK;
    full = (len >= DEPTH);
    last = (len == 0) ? 0 : int'(len) - 1;
    if (kind == K_PREPEND || kind == K_APPEND) begin
      if (full) st = ST_FULL;
      else if (kind == K_PREPEND) push_front(v);
      else push_back(v);
    end else if (kind == K_GOTO) begin
      if (idx >= len) st = ST_RANGE;
      else begin
        cur = node_at(idx);
        cur_pos = idx;
      end
    end else if (len == 0) begin
      st = ST_EMPTY;
    end else if (kind == K_INS_AFTER || kind == K_INS_BEFORE) begin
      if (full) st = ST_FULL;
      else if (kind == K_INS_AFTER && cur_pos == last) push_back(v);
      else if (kind == K_INS_BEFORE && cur_pos == 0) push_front(v);
      else if (kind == K_INS_AFTER) begin
        c = cur;
        n = grab_node(v);
        pool_link[n] = pool_link[c];
        pool_link[c] = n;
        cur = n;
        cur_pos++;
        len++;
      end else begin
        b = node_at(int'(cur_pos) - 1);
        n = grab_node(v);
        pool_link[n] = cur;
        pool_link[b] = n;
        cur = n;
        len++;
      end
    end else if (kind == K_UPDATE) begin
      pool_data[cur] = v;
    end else if (kind == K_DELETE) begin
      c = cur;
      if (cur_pos == 0) begin
        head = pool_link[c];
        if (last == 0) tail = head;
      end else begin
        b = node_at(int'(cur_pos) - 1);
        pool_link[b] = pool_link[c];
        if (cur_pos == last) tail = b;
      end
      pool_link[c] = free_head;
      free_head = c;
      len--;
      cur = head;
      cur_pos = 0;
    end else if (kind == K_FIRST) begin
      cur = head;
      cur_pos = 0;
    end else if (kind == K_LAST) begin
      cur = tail;
      cur_pos = 8'(last);
    end else if (kind == K_NEXT) begin
      if (cur_pos >= last) st = ST_BOUNDARY;
      else begin
        cur = pool_link[cur];
        cur_pos++;
      end
    end else if (kind == K_PREV) begin
      if (cur_pos == 0) st = ST_BOUNDARY;
      else begin
        cur_pos--;
        cur = node_at(cur_pos);
      end
    end else if (kind == K_FIND) begin
      st = ST_NOTFOUND;
      p = head;
      for (int i = 0; i < len; i++) begin
        if (pool_data[p] == v) begin
          cur = p;
          cur_pos = 8'(i);
          st = ST_OK;
          break;
        end
        p = pool_link[p];
      end
    end
    // Read and the unused codes leave the state alone.
    rep = '0;
    rep.status = st;
    rep.count = len;
    if (len != 0) begin
      rep.value = pool_data[cur];
      rep.position = cur_pos;
      rep.at_first = (cur_pos == 0);
      rep.at_last = (cur_pos == len - 1);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endtask

  initial begin
    failures = 0;
    for (int i = 0; i < DEPTH; i++) begin
      pool_data[i] = '0;
      pool_link[i] = 8'((i + 1) % DEPTH);
    end
    head = 0;
    tail = 0;
    cur = 0;
    cur_pos = 0;
    len = 0;
    free_head = 0;
  end

  always @(posedge clk) begin
    cursor_report_t want, got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_reports.size() == 0) begin
          $display("%0t: result with nothing expected, actual %0h", $time, m_tdata);
          failures++;
        end else begin
          want = pending_reports.pop_front();
          check_field("status", want.status, got.status);
          check_field("cur_value", want.value, got.value);
          check_field("cur_position", want.position, got.position);
          check_field("count", want.count, got.count);
          check_field("at_first", want.at_first, got.at_first);
          check_field("at_last", want.at_last, got.at_last);
          check_field("pad", want.pad, got.pad);
        end
      end
      if (s_tvalid && s_tready) begin
        apply_op(s_tuser, s_tdata[31:0], s_tdata[39:32], want);
        pending_reports.push_back(want);
      end
    end
  end

endmodule

/* tb/cursor_list_engine_tb.sv */
// Testbench top for the cursor list engine: clock, reset, operation stimulus,
// random back-pressure and the verdict. Depends on cle_pkg, cle_checker and the block.
`timescale 1ns / 100ps
module cursor_list_engine_tb;
  import cle_pkg::*;

  localparam logic [3:0] K_READ = 4'd12;
  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  int          failures, outstanding, list_len;
  bit          hold_req = 1'b0;
  int          idle_cycles = 0;
  logic [31:0] value_pool [8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cursor_list_engine u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  cle_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .failures(failures), .outstanding(outstanding), .list_len(list_len)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  task automatic send_op(logic [3:0] kind, logic [31:0] v, logic [7:0] idx);
    int g;
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {idx, v};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 1)) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_index();
    int top;
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    top = list_len + 2;
    if (top > 255) top = 255;
    return 8'($urandom_range(0, top));
  endfunction

  // Weighted operation mix; shrink_bias favours deletes over inserts.
  task automatic random_op(bit shrink_bias);
    int r;
    logic [3:0] kind;
    r = $urandom_range(0, 99);
    if (r < 10) kind = K_APPEND;
    else if (r < 18) kind = K_PREPEND;
    else if (r < 25) kind = K_INS_AFTER;
    else if (r < 32) kind = K_INS_BEFORE;
    else if (r < 38) kind = K_UPDATE;
    else if (r < 46) kind = K_DELETE;
    else if (r < 50) kind = K_FIRST;
    else if (r < 54) kind = K_LAST;
    else if (r < 64) kind = K_NEXT;
    else if (r < 72) kind = K_PREV;
    else if (r < 80) kind = K_GOTO;
    else if (r < 90) kind = K_FIND;
    else if (r < 96) kind = K_READ;
    else kind = 4'($urandom_range(13, 15));
    if (shrink_bias && kind <= K_INS_BEFORE && $urandom_range(0, 2) != 0) kind = K_DELETE;
    send_op(kind, pick_value(), pick_index());
  endtask

  // Receiver: runs of ready and stall, plus one long hold-off on request.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end
      n = gap_len();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 400)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: the codes from insert-after to read on the empty list, then a small list walked to its ends.
    for (int k = 2; k <= 12; k++) send_op(4'(k), 32'h1234_5678, 8'd0);
    send_op(K_GOTO, 32'h0, 8'd255);
    send_op(K_APPEND, 32'h7fff_ffff, 8'd0);
    send_op(K_PREPEND, 32'h8000_0000, 8'd0);
    send_op(K_INS_BEFORE, 32'h0, 8'd0);
    send_op(K_LAST, 32'h0, 8'd0);
    send_op(K_INS_AFTER, 32'hffff_ffff, 8'd0);
    send_op(K_NEXT, 32'h0, 8'd0);
    send_op(K_FIRST, 32'h0, 8'd0);
    send_op(K_PREV, 32'h0, 8'd0);
    send_op(K_FIND, 32'h7fff_ffff, 8'd0);
    send_op(K_FIND, 32'h5555_aaaa, 8'd0);
    send_op(K_GOTO, 32'h0, 8'd4);
    send_op(K_GOTO, 32'h0, 8'd2);
    send_op(K_DELETE, 32'h0, 8'd0);
    send_op(4'd15, 32'h0, 8'd0);

    // Mixed random operations with one long receiver hold-off in the middle.
    for (int i = 0; i < 100; i++) begin
      if (i == 40) hold_req = 1'b1;
      random_op(1'b0);
    end

    // Fill the pool to capacity, then hit it with inserts and the far end.
    while (list_len < 256) begin
      if ($urandom_range(0, 3) == 0) send_op(K_INS_AFTER, pick_value(), 8'd0);
      else send_op(K_APPEND, pick_value(), 8'd0);
    end
    for (int k = 0; k < 4; k++) send_op(4'(k), $urandom, 8'd0);
    send_op(K_GOTO, 32'h0, 8'd255);
    send_op(K_NEXT, 32'h0, 8'd0);
    send_op(K_PREV, 32'h0, 8'd0);
    send_op(K_FIND, $urandom, 8'd0);

    // Sender pause until every result has come back.
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);

    for (int i = 0; i < 60; i++) random_op(1'b1);
    for (int i = 0; i < 120; i++) random_op(1'b0);

    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (300) @(posedge clk);
    if (failures == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
